FILE: rtl/mtfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtfe_pkg;

	// symbol and position width
	localparam int SYM_W = 8;

	// result for a symbol that no table entry holds
	localparam logic [SYM_W-1:0] NO_MATCH = 8'hFF;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_ENC,
		ST_UPD
	} mtfe_state_t;

	// broadcast control shared by all cells
	typedef struct packed {
		logic             load_id;
		logic             cmp_en;
		logic             upd_en;
		logic [SYM_W-1:0] symbol;
		logic [SYM_W-1:0] pos;
	} mtfe_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/mtfe_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One table entry: holds a symbol, flags a match, takes its left neighbor on a move
module mtfe_cell
	import mtfe_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mtfe_ctrl_t       ctrl,
	input  wire logic [SYM_W-1:0] prev_entry,
	output logic      [SYM_W-1:0] entry,
	output logic                  match
);

	logic [SYM_W-1:0] entry_q;
	logic             match_q;
	logic             shift_en;

	// this entry moves back when the found symbol sits at or after it
	assign shift_en = ctrl.upd_en && (ctrl.pos >= SYM_W'(IDX));

	// entry storage, identity at reset and on start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= SYM_W'(IDX);
		end else if (ctrl.load_id) begin
			entry_q <= SYM_W'(IDX);
		end else if (shift_en) begin
			entry_q <= prev_entry;
		end
	end

	// compare against the broadcast symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			match_q <= (entry_q == ctrl.symbol);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

`default_nettype wire

FILE: rtl/mtfe_enc.sv
`timescale 1ns / 1ps
`default_nettype none

// Turns the one-hot match row into a position
module mtfe_enc
	import mtfe_pkg::*;
#(
	parameter int SYMBOL_COUNT = 256
) (
	input  wire logic [SYMBOL_COUNT-1:0] match,
	output logic      [SYM_W-1:0]        pos,
	output logic                         found
);

	// OR tree: at most one cell matches since the table is a permutation
	always_comb begin
		pos = '0;
		for (int k = 0; k < SYMBOL_COUNT; k++) begin
			if (match[k]) begin
				pos = pos | SYM_W'(k);
			end
		end
	end

	assign found = |match;

endmodule

`default_nettype wire

FILE: rtl/move_to_front_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte move-to-front encoder. Each item carries a symbol and a start flag;
// the start flag restores the table to identity order before the symbol is
// looked up. The result is the symbol's position before it moves to the
// front, or 255 when the symbol lies outside a table smaller than 256.
// The table is a row of SYMBOL_COUNT cells that compare against the
// broadcast symbol together and shift toward the back as one.
// An item goes through accept, compare in the cells, encode the position,
// then move the entries and load the result register once the output is
// free. Items are worked one at a time; the next item is taken while a
// result waits on the output. The table is at identity right after reset.
module move_to_front_encoder_unit
	import mtfe_pkg::*;
#(
	parameter int SYMBOL_COUNT = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [SYM_W-1:0] s_tdata,   // [7:0] symbol
	input  wire logic             s_tuser,   // [0] start_req
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [SYM_W-1:0] m_tdata    // [7:0] mtf_index
);

	mtfe_state_t      state_q, state_nxt;
	logic [SYM_W-1:0] sym_q;
	logic [SYM_W-1:0] pos_q;
	logic             found_q;
	logic             out_valid_q;
	logic [SYM_W-1:0] out_data_q;

	logic                    in_acc;
	logic                    out_free;
	logic                    upd_go;
	logic [SYMBOL_COUNT-1:0] match;
	logic [SYM_W-1:0]        enc_pos;
	logic                    enc_found;
	logic [SYM_W-1:0]        entry [SYMBOL_COUNT];
	mtfe_ctrl_t              ctrl;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_nxt = ST_CMP;
			ST_CMP:  state_nxt = ST_ENC;
			ST_ENC:  state_nxt = ST_UPD;
			ST_UPD:  if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready     = 1'b0;
		ctrl.cmp_en  = 1'b0;
		upd_go       = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_CMP:  ctrl.cmp_en = 1'b1;
			ST_ENC:  ;
			ST_UPD:  upd_go = out_free;
			default: ;
		endcase
		ctrl.load_id = in_acc && s_tuser;
		ctrl.upd_en  = upd_go && found_q;
		ctrl.symbol  = sym_q;
		ctrl.pos     = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sym_q <= s_tdata;
		end
	end

	// registered position
	always_ff @(posedge clk) begin
		if (state_q == ST_ENC) begin
			pos_q <= enc_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (state_q == ST_ENC) begin
			found_q <= enc_found;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_data_q <= found_q ? pos_q : NO_MATCH;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// cell row; the front cell takes the symbol itself
	for (genvar k = 0; k < SYMBOL_COUNT; k++) begin : g_cell
		logic [SYM_W-1:0] prev;
		if (k == 0) begin : g_front
			assign prev = sym_q;
		end else begin : g_rest
			assign prev = entry[k-1];
		end
		mtfe_cell #(
			.IDX(k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.prev_entry(prev),
			.entry     (entry[k]),
			.match     (match[k])
		);
	end

	mtfe_enc #(
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_enc (
		.match(match),
		.pos  (enc_pos),
		.found(enc_found)
	);

endmodule

`default_nettype wire
